[sv/clock_divider_prescaler_solver_assert.svh]
// Assertion macros for the prescaler solver
`ifndef CLOCK_DIVIDER_PRESCALER_SOLVER_ASSERT_SVH
`define CLOCK_DIVIDER_PRESCALER_SOLVER_ASSERT_SVH
// same-cycle implication
`define CDPS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("cdps check failed");
// next-cycle implication
`define CDPS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("cdps check failed");
`endif

[sv/cdps_pkg.sv]
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared types and constants of the timer prescaler solver.
// ----------------------------------------------------------------------------
package cdps_pkg;

  localparam int unsigned NumW   = 31;
  localparam int unsigned DenW   = 32;
  localparam logic [31:0] ClockReset = 32'd16000000;

  typedef enum logic [1:0] {
    KIND_T8   = 2'd0,
    KIND_T16  = 2'd1,
    KIND_T8X  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_WIDE  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  timer_kind;
    logic [31:0] target_hz;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  prescaler_code;
    logic [31:0] compare_value;
    logic [30:0] actual_hz;
  } out_t;

  typedef struct packed {
    logic            bad;
    logic [1:0]      kind;
    logic [31:0]     target;
    logic [NumW-1:0] half;
    logic [DenW-1:0] hi;
    logic [2:0]      code;
    logic [31:0]     cmp;
    logic [1:0]      status;
  } ctx_t;

endpackage

[sv/cdps_div.sv]
// ----------------------------------------------------------------------------
// cdps_div
// Pipelined restoring divider, one quotient bit per stage, item context rides along.
// ----------------------------------------------------------------------------
module cdps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [cdps_pkg::NumW-1:0]     n_i,
  input  logic [cdps_pkg::DenW-1:0]     d_i,
  input  cdps_pkg::ctx_t                ctx_i,
  output logic                          vld_o,
  output logic [cdps_pkg::NumW-1:0]     q_o,
  output cdps_pkg::ctx_t                ctx_o
);

  localparam int unsigned N = cdps_pkg::NumW;
  localparam int unsigned D = cdps_pkg::DenW;

  logic [D-1:0]   rem_r [N];
  logic [N-1:0]   num_r [N];
  logic [N-1:0]   quo_r [N];
  logic [D-1:0]   den_r [N];
  cdps_pkg::ctx_t ctx_r [N];
  logic [N-1:0]   vld_r;

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [D-1:0]   rem_in;
    logic [N-1:0]   num_in;
    logic [N-1:0]   quo_in;
    logic [D-1:0]   den_in;
    cdps_pkg::ctx_t ctx_in;
    logic           vld_in;
    logic [D:0]     trial;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = n_i;
      assign quo_in = '0;
      assign den_in = d_i;
      assign ctx_in = ctx_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign ctx_in = ctx_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    assign trial = {rem_in, num_in[N-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? D'(trial - {1'b0, den_in}) : trial[D-1:0];
        num_r[s] <= {num_in[N-2:0], 1'b0};
        quo_r[s] <= {quo_in[N-2:0], ge};
        den_r[s] <= den_in;
        ctx_r[s] <= ctx_in;
      end
    end
  end

  assign vld_o = vld_r[N-1];
  assign q_o   = quo_r[N-1];
  assign ctx_o = ctx_r[N-1];

endmodule

[sv/clock_divider_prescaler_solver.sv]
// ----------------------------------------------------------------------------
// clock_divider_prescaler_solver
// Picks timer prescaler code and compare value for a requested toggle rate.
//
// Input channel in_valid/in_ready/in_data carries timer kind and target rate.
// Result channel out_valid/out_ready/out_data returns status, prescaler code,
// compare value and achieved rate, one result per item, in order.
// cfg_valid/cfg_ready/cfg_data writes the input clock rate; cfg_ready is
// always high. Write it only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls; three 31-stage
// bit-per-stage divider pipelines (floor divisor, the two candidate rates,
// final rate) set the depth.
// Reset clears all valid bits and loads the clock rate with 16 MHz.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "clock_divider_prescaler_solver_assert.svh"

module clock_divider_prescaler_solver (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cdps_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);

  localparam int unsigned N = cdps_pkg::NumW;
  localparam int unsigned D = cdps_pkg::DenW;

  logic [31:0]    clock_hz_r;
  logic           en;
  logic           out_valid_r;
  cdps_pkg::out_t out_data_r;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= cdps_pkg::ClockReset;
    end else if (cfg_valid) begin
      clock_hz_r <= cfg_data;
    end
  end

  // first division: floor divisor
  logic [N-1:0]   half;
  logic           bad;
  cdps_pkg::ctx_t c0;
  logic           v1;
  logic [N-1:0]   q1;
  cdps_pkg::ctx_t c1;

  assign half = clock_hz_r[31:1];
  assign bad  = (in_data.target_hz == '0) || (in_data.target_hz > {1'b0, half});

  always_comb begin
    c0        = '0;
    c0.bad    = bad;
    c0.kind   = in_data.timer_kind;
    c0.target = in_data.target_hz;
    c0.half   = half;
  end

  cdps_div u_div_hi (
    .clk, .rst_n, .en,
    .vld_i (in_valid && en),
    .n_i   (half),
    .d_i   (bad ? D'(1) : in_data.target_hz),
    .ctx_i (c0),
    .vld_o (v1),
    .q_o   (q1),
    .ctx_o (c1)
  );

  // candidate rates for floor and floor+1
  cdps_pkg::ctx_t c1h;
  logic           v2;
  logic [N-1:0]   f_hi;
  logic [N-1:0]   f_lo;
  cdps_pkg::ctx_t c2;

  always_comb begin
    c1h    = c1;
    c1h.hi = D'(q1);
  end

  cdps_div u_div_fhi (
    .clk, .rst_n, .en,
    .vld_i (v1),
    .n_i   (c1.half),
    .d_i   (D'(q1)),
    .ctx_i (c1h),
    .vld_o (v2),
    .q_o   (f_hi),
    .ctx_o (c2)
  );

  cdps_div u_div_flo (
    .clk, .rst_n, .en,
    .vld_i (v1),
    .n_i   (c1.half),
    .d_i   (D'(q1) + D'(1)),
    .ctx_i ('0),
    .vld_o (),
    .q_o   (f_lo),
    .ctx_o ()
  );

  // choose divisor, prescaler and compare value
  function automatic logic [6:0] pick(input logic [1:0] kind, input logic [31:0] dv);
    logic [2:0] code;
    logic [3:0] sh;
    code = 3'd1;
    sh   = 4'd0;
    unique case (cdps_pkg::kind_t'(kind))
      cdps_pkg::KIND_T8: begin
        if (dv > 32'd256 && dv <= 32'd2048)                begin code = 3'd2; sh = 4'd3;  end
        else if (dv > 32'd2048 && dv <= 32'd16384)         begin code = 3'd3; sh = 4'd6;  end
        else if (dv > 32'd16384 && dv <= 32'd65536)        begin code = 3'd4; sh = 4'd8;  end
        else if (dv > 32'd65536 && dv <= 32'd262144)       begin code = 3'd5; sh = 4'd10; end
      end
      cdps_pkg::KIND_T8X: begin
        if (dv > 32'd256 && dv <= 32'd2048)                begin code = 3'd2; sh = 4'd3;  end
        else if (dv > 32'd2048 && dv <= 32'd8192)          begin code = 3'd3; sh = 4'd5;  end
        else if (dv > 32'd8192 && dv <= 32'd16384)         begin code = 3'd4; sh = 4'd6;  end
        else if (dv > 32'd16384 && dv <= 32'd32768)        begin code = 3'd5; sh = 4'd7;  end
        else if (dv > 32'd32768 && dv <= 32'd65536)        begin code = 3'd6; sh = 4'd8;  end
        else if (dv > 32'd65536 && dv <= 32'd262144)       begin code = 3'd7; sh = 4'd10; end
      end
      cdps_pkg::KIND_T16: begin
        if (dv > 32'd65536 && dv <= 32'd524288)            begin code = 3'd2; sh = 4'd3;  end
        else if (dv > 32'd524288 && dv <= 32'd4194304)     begin code = 3'd3; sh = 4'd6;  end
        else if (dv > 32'd4194304 && dv <= 32'd16777216)   begin code = 3'd4; sh = 4'd8;  end
        else if (dv > 32'd16777216 && dv <= 32'd67108864)  begin code = 3'd5; sh = 4'd10; end
      end
      default: begin
        code = 3'd1;
        sh   = 4'd0;
      end
    endcase
    return {code, sh};
  endfunction

  logic [31:0]    dh;
  logic [31:0]    dl;
  logic [31:0]    dv_nxt;
  logic           vd_r;
  logic [31:0]    dv_r;
  cdps_pkg::ctx_t cd_r;
  logic [6:0]     pk;
  logic [31:0]    sc0;
  logic [31:0]    scaled;
  logic [31:0]    cmp;
  logic [1:0]     st;
  logic [N-1:0]   v3_n_nxt;
  cdps_pkg::ctx_t c3_nxt;
  logic           v3_r;
  logic [N-1:0]   n3_r;
  logic [D-1:0]   d3_r;
  cdps_pkg::ctx_t c3_r;

  assign dh     = 32'(f_hi) - c2.target;
  assign dl     = c2.target - 32'(f_lo);
  assign dv_nxt = (dh < dl) ? c2.hi : c2.hi + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
      cd_r <= c2;
    end
  end

  assign pk     = pick(cd_r.kind, dv_r);
  assign sc0    = dv_r >> pk[3:0];
  assign scaled = (sc0 == '0) ? 32'd1 : sc0;
  assign cmp    = scaled - 32'd1;
  assign v3_n_nxt = cd_r.half >> pk[3:0];

  always_comb begin
    unique case (cdps_pkg::kind_t'(cd_r.kind))
      cdps_pkg::KIND_T8, cdps_pkg::KIND_T8X:
        st = (cmp > 32'd255) ? cdps_pkg::ST_WIDE : cdps_pkg::ST_OK;
      cdps_pkg::KIND_T16:
        st = (cmp > 32'd65535) ? cdps_pkg::ST_WIDE : cdps_pkg::ST_OK;
      default:
        st = cdps_pkg::ST_WIDE;
    endcase
  end

  always_comb begin
    c3_nxt        = cd_r;
    c3_nxt.code   = pk[6:4];
    c3_nxt.cmp    = cmp;
    c3_nxt.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r <= v3_n_nxt;
      d3_r <= scaled;
      c3_r <= c3_nxt;
    end
  end

  // final rate
  logic           v4;
  logic [N-1:0]   q4;
  cdps_pkg::ctx_t c4;

  cdps_div u_div_act (
    .clk, .rst_n, .en,
    .vld_i (v3_r),
    .n_i   (n3_r),
    .d_i   (d3_r),
    .ctx_i (c3_r),
    .vld_o (v4),
    .q_o   (q4),
    .ctx_o (c4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (c4.bad) begin
        out_data_r.status         <= cdps_pkg::ST_RANGE;
        out_data_r.prescaler_code <= 3'd1;
        out_data_r.compare_value  <= '0;
        out_data_r.actual_hz      <= '0;
      end else begin
        out_data_r.status         <= c4.status;
        out_data_r.prescaler_code <= c4.code;
        out_data_r.compare_value  <= c4.cmp;
        out_data_r.actual_hz      <= q4;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CDPS_ASSERT_IMP(a_ready_rule, 1'b1, in_ready == (!out_valid_r || out_ready))
  `CDPS_ASSERT_IMP(a_range_zero, out_valid && out_data.status == cdps_pkg::ST_RANGE,
    out_data.actual_hz == '0 && out_data.compare_value == '0)
  `CDPS_ASSERT_IMP(a_code_nz, out_valid, out_data.prescaler_code != 3'd0)
  `CDPS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

[tb/clock_divider_prescaler_solver_checker.sv]
// ----------------------------------------------------------------------------
// clock_divider_prescaler_solver_checker
// Watches the item and result channels of the prescaler solver, computes the
// expected prescaler code, compare value, achieved rate and status for every
// accepted item, and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module clock_divider_prescaler_solver_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cdps_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cdps_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending
);

  logic [31:0]    clk_rate;
  cdps_pkg::out_t solved_q[$];

  function automatic cdps_pkg::out_t solve_prescaler(logic [31:0] rate, cdps_pkg::in_t req);
    cdps_pkg::out_t r;
    logic [63:0]    half, tgt, hi, lo, f_hi, f_lo, dv, ratio, scaled;
    logic [2:0]     code;
    half = {32'd0, rate} / 64'd2;
    tgt  = {32'd0, req.target_hz};
    r = '0;
    if (tgt == 64'd0 || tgt > half) begin
      r.status = cdps_pkg::ST_RANGE;
      r.prescaler_code = 3'd1;
      return r;
    end
    hi = half / tgt;
    lo = hi + 64'd1;
    f_hi = half / hi;
    f_lo = half / lo;
    dv = ((f_hi - tgt) < (tgt - f_lo)) ? hi : lo;
    code = 3'd1;
    ratio = 64'd1;
    case (req.timer_kind)
      cdps_pkg::KIND_T8: begin
        if (dv > 256 && dv <= 2048) begin code = 3'd2; ratio = 64'd8; end
        else if (dv > 2048 && dv <= 16384) begin code = 3'd3; ratio = 64'd64; end
        else if (dv > 16384 && dv <= 65536) begin code = 3'd4; ratio = 64'd256; end
        else if (dv > 65536 && dv <= 262144) begin code = 3'd5; ratio = 64'd1024; end
      end
      cdps_pkg::KIND_T8X: begin
        if (dv > 256 && dv <= 2048) begin code = 3'd2; ratio = 64'd8; end
        else if (dv > 2048 && dv <= 8192) begin code = 3'd3; ratio = 64'd32; end
        else if (dv > 8192 && dv <= 16384) begin code = 3'd4; ratio = 64'd64; end
        else if (dv > 16384 && dv <= 32768) begin code = 3'd5; ratio = 64'd128; end
        else if (dv > 32768 && dv <= 65536) begin code = 3'd6; ratio = 64'd256; end
        else if (dv > 65536 && dv <= 262144) begin code = 3'd7; ratio = 64'd1024; end
      end
      cdps_pkg::KIND_T16: begin
        if (dv > 65536 && dv <= 524288) begin code = 3'd2; ratio = 64'd8; end
        else if (dv > 524288 && dv <= 4194304) begin code = 3'd3; ratio = 64'd64; end
        else if (dv > 4194304 && dv <= 16777216) begin code = 3'd4; ratio = 64'd256; end
        else if (dv > 16777216 && dv <= 67108864) begin code = 3'd5; ratio = 64'd1024; end
      end
      default: ;
    endcase
    scaled = dv / ratio;
    if (scaled == 64'd0) scaled = 64'd1;
    r.prescaler_code = code;
    r.compare_value  = 32'(scaled - 64'd1);
    r.actual_hz      = 31'((half / ratio) / scaled);
    r.status = cdps_pkg::ST_OK;
    case (req.timer_kind)
      cdps_pkg::KIND_T8, cdps_pkg::KIND_T8X:
        if (scaled - 64'd1 > 64'd255) r.status = cdps_pkg::ST_WIDE;
      cdps_pkg::KIND_T16:
        if (scaled - 64'd1 > 64'd65535) r.status = cdps_pkg::ST_WIDE;
      default:
        r.status = cdps_pkg::ST_WIDE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : p_check
    cdps_pkg::out_t want;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      clk_rate   <= cdps_pkg::ClockReset;
      fail_count <= 0;
      pending    <= 0;
      solved_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) clk_rate <= cfg_data;
      if (in_valid && in_ready) solved_q.push_back(solve_prescaler(clk_rate, in_data));
      if (out_valid && out_ready) begin
        if (solved_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errs = errs + 1;
        end else begin
          want = solved_q.pop_front();
          if (want.status !== out_data.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
            errs = errs + 1;
          end
          if (want.prescaler_code !== out_data.prescaler_code) begin
            $display("%0t: code expected %0d actual %0d", $time,
                     want.prescaler_code, out_data.prescaler_code);
            errs = errs + 1;
          end
          if (want.compare_value !== out_data.compare_value) begin
            $display("%0t: compare expected %0d actual %0d", $time,
                     want.compare_value, out_data.compare_value);
            errs = errs + 1;
          end
          if (want.actual_hz !== out_data.actual_hz) begin
            $display("%0t: rate expected %0d actual %0d", $time, want.actual_hz,
                     out_data.actual_hz);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= solved_q.size();
    end
  end
endmodule

[tb/tb_clock_divider_prescaler_solver.sv]
// ----------------------------------------------------------------------------
// tb_clock_divider_prescaler_solver
// Drives requests at the prescaler solver over several clock rates, with
// directed corner items then random ones under varying idle and stall, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_clock_divider_prescaler_solver;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  cdps_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  cdps_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [31:0]    cfg_data = '0;
  int             fail_count;
  int             pending;
  int             send_idle = 0;
  int             recv_idle = 0;
  logic           hold_off = 1'b0;
  int             quiet = 0;
  logic [31:0]    cur_rate = cdps_pkg::ClockReset;

  always #5 clk = ~clk;

  clock_divider_prescaler_solver u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  clock_divider_prescaler_solver_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] kind, logic [31:0] tgt);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{timer_kind: kind, target_hz: tgt};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_rate(logic [31:0] rate);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_rate = rate;
  endtask

  function automatic logic [31:0] rand_target(logic [31:0] rate);
    logic [31:0] half;
    half = rate >> 1;
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3);
      2: return (half == 0) ? 32'd1 : $urandom_range(half, 1);
      3: return half + $urandom_range(1, 0);
      4: return (half >> $urandom_range(28)) + $urandom_range(2);
      default: return $urandom_range(100000, 1);
    endcase
  endfunction

  task automatic rand_phase(int n);
    repeat (n) send_item(2'($urandom_range(3)), rand_target(cur_rate));
  endtask

  task automatic directed();
    logic [1:0] k;
    for (int i = 0; i < 4; i++) begin
      k = 2'(i);
      send_item(k, 32'd0);
      send_item(k, 32'hFFFF_FFFF);
      send_item(k, cur_rate >> 1);
      send_item(k, (cur_rate >> 1) + 1);
      send_item(k, 32'd1);
    end
    send_item(cdps_pkg::KIND_T8, 32'd3);
    send_item(cdps_pkg::KIND_T8X, 32'd300);
    send_item(cdps_pkg::KIND_T16, 32'd61);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    send_idle = 12;
    recv_idle = 65;
    rand_phase(300);
    write_rate(32'd2);
    directed();
    write_rate(32'd3);
    rand_phase(100);
    write_rate(32'hFFFF_FFFF);
    directed();
    send_idle = 65;
    recv_idle = 12;
    rand_phase(400);
    write_rate(32'd20000000);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      rand_phase(250);
    join
    send_idle = 0;
    recv_idle = 0;
    write_rate($urandom());
    rand_phase(400);
    write_rate(32'd1000);
    rand_phase(100);
    write_rate(cdps_pkg::ClockReset);
    rand_phase(300);
    drain_all();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
